// ===== sv/fsba_pkg.sv =====
`timescale 1ns / 1ps

package fsba_pkg;

  localparam int unsigned MAX_SLOTS_DEF = 64;

  localparam logic [32:0] MIN_SLOT_BYTES = 33'd256;
  localparam logic [31:0] POW2_LIMIT     = 32'h8000_0000;
  localparam logic [31:0] CAP_RESET      = 32'd256;
  localparam logic [6:0]  ACTIVE_RESET   = 7'd64;

  typedef enum logic {
    OP_ACQUIRE = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_TOO_LARGE   = 2'd1,
    ST_NO_FREE     = 2'd2,
    ST_BAD_RELEASE = 2'd3
  } status_e;

  typedef enum logic {
    CFG_REGION_CAPACITY = 1'b0,
    CFG_ACTIVE_SLOTS    = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SIZE,
    S_SCAN
  } state_e;

  typedef struct packed {
    op_e         op;
    logic        too_large;
    logic [31:0] idx;
  } scan_cmd_t;

  typedef struct packed {
    status_e     status;
    logic [5:0]  granted;
    logic [6:0]  free_cnt;
    logic        idle;
  } scan_res_t;

endpackage

// ===== sv/fsba_size_unit.sv =====
`timescale 1ns / 1ps

module fsba_size_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] cap_i,
  output logic        done_o,
  output logic [32:0] size_o
);

  logic        busy_q, busy_d;
  logic [32:0] size_q, size_d;
  logic        big;
  logic        below;
  logic [32:0] rounded;

  // Capacities above 2^31 are rounded to a multiple of 256 directly, without doubling.
  assign big     = cap_i > fsba_pkg::POW2_LIMIT;
  assign rounded = ({1'b0, cap_i} + (fsba_pkg::MIN_SLOT_BYTES - 33'd1)) &
                   ~(fsba_pkg::MIN_SLOT_BYTES - 33'd1);
  assign below   = size_q < {1'b0, cap_i};

  always_comb begin
    busy_d = busy_q;
    size_d = size_q;
    if (start_i) begin
      busy_d = 1'b1;
      size_d = big ? rounded : fsba_pkg::MIN_SLOT_BYTES;
    end else if (busy_q) begin
      if (below) begin
        size_d = {size_q[31:0], 1'b0};
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    size_q <= size_d;
  end

  assign done_o = busy_q && !below;
  assign size_o = size_q;

endmodule

// ===== sv/fsba_bitmap.sv =====
`timescale 1ns / 1ps

module fsba_bitmap #(
  parameter int unsigned MAX_SLOTS = fsba_pkg::MAX_SLOTS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  fsba_pkg::scan_cmd_t                cmd_i,
  input  logic [$clog2(MAX_SLOTS+1)-1:0]     n_i,
  input  logic                               commit_ok_i,
  output logic                               done_o,
  output fsba_pkg::scan_res_t                res_o
);

  localparam int unsigned CW = $clog2(MAX_SLOTS + 1);
  localparam int unsigned IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  logic                 busy_q, busy_d;
  logic [CW-1:0]        i_q, i_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 found_q, found_d;
  logic [IW-1:0]        first_q, first_d;
  logic                 hit_q, hit_d;
  fsba_pkg::scan_cmd_t  cmd_q, cmd_d;
  logic [MAX_SLOTS-1:0] slot_out_q, slot_out_d;

  logic          rd_bit;
  logic          step;
  logic          commit;
  logic [CW-1:0] free_after;
  logic [31:0]   free_wide;
  logic [31:0]   first_wide;

  assign rd_bit     = slot_out_q[i_q[IW-1:0]];
  assign step       = busy_q && (i_q != n_i);
  assign done_o     = busy_q && (i_q == n_i);
  assign commit     = done_o && commit_ok_i;
  assign free_wide  = 32'(free_after);
  assign first_wide = 32'(first_q);

  always_comb begin
    res_o          = '0;
    res_o.status   = fsba_pkg::ST_OK;
    free_after     = cnt_q;
    slot_out_d     = slot_out_q;
    if (cmd_q.op == fsba_pkg::OP_ACQUIRE) begin
      if (cmd_q.too_large) begin
        res_o.status = fsba_pkg::ST_TOO_LARGE;
      end else if (found_q) begin
        res_o.granted = first_wide[5:0];
        free_after    = cnt_q - CW'(1);
        slot_out_d[first_q] = 1'b1;
      end else begin
        res_o.status = fsba_pkg::ST_NO_FREE;
      end
    end else begin
      if (hit_q) begin
        free_after = cnt_q + CW'(1);
        slot_out_d[cmd_q.idx[IW-1:0]] = 1'b0;
      end else begin
        res_o.status = fsba_pkg::ST_BAD_RELEASE;
      end
    end
    res_o.free_cnt = free_wide[6:0];
    res_o.idle     = free_after == n_i;
  end

  always_comb begin
    busy_d  = busy_q;
    i_d     = i_q;
    cnt_d   = cnt_q;
    found_d = found_q;
    first_d = first_q;
    hit_d   = hit_q;
    cmd_d   = cmd_q;
    if (start_i) begin
      busy_d  = 1'b1;
      i_d     = '0;
      cnt_d   = '0;
      found_d = 1'b0;
      first_d = '0;
      hit_d   = 1'b0;
      cmd_d   = cmd_i;
    end else if (step) begin
      i_d = i_q + CW'(1);
      if (!rd_bit) begin
        cnt_d = cnt_q + CW'(1);
        if (!found_q) begin
          found_d = 1'b1;
          first_d = i_q[IW-1:0];
        end
      end
      if (rd_bit && (32'(i_q) == cmd_q.idx)) begin
        hit_d = 1'b1;
      end
    end else if (commit) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      slot_out_q <= '0;
    end else begin
      busy_q <= busy_d;
      if (commit) begin
        slot_out_q <= slot_out_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_q     <= i_d;
    cnt_q   <= cnt_d;
    found_q <= found_d;
    first_q <= first_d;
    hit_q   <= hit_d;
    cmd_q   <= cmd_d;
  end

endmodule

// ===== sv/fixed_slot_bitmap_allocator.sv =====
`timescale 1ns / 1ps

// Slot allocator that hands out equal-size slots from a bitmap of MAX_SLOTS bits.
// Requests enter on a valid/ready channel (operation, request_capacity,
// release index); each request yields exactly one response on a valid/ready output
// channel (status, granted_slot, free_count, idle). The configuration port writes
// region_capacity (index 0) and active_slots (index 1); the user must do so only
// while no request is open, since the block itself does not enforce it. A request
// first derives the slot size by doubling from 256 in a shift and compare unit,
// 0 to 23 times (or not at all above 2^31), then scans the bitmap one slot per
// cycle over the n active slots. A new request is taken only once the previous
// one has loaded its response into the output register.
// The response sits in an output register, so the next request is accepted while
// it waits; if the receiver still stalls when that request finishes its scan,
// the scan holds its result and the bitmap is not updated until the register
// frees. Reset clears the bitmap (every slot free), sets region_capacity to 256
// and active_slots to 64.
module fixed_slot_bitmap_allocator #(
  parameter int unsigned MAX_SLOTS = fsba_pkg::MAX_SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [63:0] request_capacity_i,
  input  logic [31:0] release_idx_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [5:0]  granted_slot_o,
  output logic [6:0]  free_count_o,
  output logic        idle_o
);

  localparam int unsigned CW = $clog2(MAX_SLOTS + 1);

  fsba_pkg::state_e    state_q, state_d;
  logic [31:0]         cap_q;
  logic [6:0]          active_q;
  fsba_pkg::op_e       op_q;
  logic [63:0]         req_q;
  logic [31:0]         idx_q;
  logic                out_valid_q, out_valid_d;
  fsba_pkg::scan_res_t res_q;

  logic                accept;
  logic                size_done;
  logic [32:0]         size_bytes;
  logic                scan_start;
  logic                scan_done;
  logic                commit_ok;
  logic                load;
  logic [CW-1:0]       n;
  fsba_pkg::scan_cmd_t scan_cmd;
  fsba_pkg::scan_res_t scan_res;

  assign accept = in_valid_i && in_ready_o;
  assign n = (32'(active_q) > 32'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : CW'(active_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q    <= fsba_pkg::CAP_RESET;
      active_q <= fsba_pkg::ACTIVE_RESET;
    end else if (cfg_we_i) begin
      case (fsba_pkg::cfg_reg_e'(cfg_index_i))
        fsba_pkg::CFG_REGION_CAPACITY: cap_q    <= cfg_wdata_i;
        fsba_pkg::CFG_ACTIVE_SLOTS:    active_q <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= fsba_pkg::op_e'(operation_i);
      req_q <= request_capacity_i;
      idx_q <= release_idx_i;
    end
  end

  fsba_size_unit u_size (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .cap_i   (cap_q),
    .done_o  (size_done),
    .size_o  (size_bytes)
  );

  assign scan_cmd.op        = op_q;
  assign scan_cmd.too_large = req_q > {31'd0, size_bytes};
  assign scan_cmd.idx       = idx_q;

  fsba_bitmap #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_bitmap (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (scan_start),
    .cmd_i       (scan_cmd),
    .n_i         (n),
    .commit_ok_i (commit_ok),
    .done_o      (scan_done),
    .res_o       (scan_res)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      fsba_pkg::S_IDLE: begin
        if (accept) state_d = fsba_pkg::S_SIZE;
      end
      fsba_pkg::S_SIZE: begin
        if (size_done) state_d = fsba_pkg::S_SCAN;
      end
      fsba_pkg::S_SCAN: begin
        if (scan_done && commit_ok) state_d = fsba_pkg::S_IDLE;
      end
      default: state_d = fsba_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    scan_start = 1'b0;
    load       = 1'b0;
    commit_ok  = 1'b0;
    case (state_q)
      fsba_pkg::S_IDLE: in_ready_o = 1'b1;
      fsba_pkg::S_SIZE: scan_start = size_done;
      fsba_pkg::S_SCAN: begin
        commit_ok = !out_valid_q || out_ready_i;
        load      = scan_done && commit_ok;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fsba_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= scan_res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = res_q.status;
  assign granted_slot_o = res_q.granted;
  assign free_count_o   = res_q.free_cnt;
  assign idle_o         = res_q.idle;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("Request accepted while the previous one is still open.");

  a_grant_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != fsba_pkg::ST_OK) |-> granted_slot_o == 6'd0)
    else $error("Nonzero granted slot on a failed request.");

  a_no_free_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == fsba_pkg::ST_NO_FREE) |-> free_count_o == 7'd0)
    else $error("No free slot reported while the free count is nonzero.");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned PHASES = 10;
  localparam int unsigned PHASE_REQUESTS = 155;
  localparam int unsigned REPORT_LINES = 50;

  typedef enum logic {
    ROW_REQUEST,
    ROW_WRITE
  } row_kind_e;

  typedef struct {
    row_kind_e           kind;
    fsba_pkg::cfg_reg_e  which;
    logic [31:0]         wdata;
    fsba_pkg::op_e       op;
    logic [63:0]         cap;
    logic [31:0]         idx;
    bit                  typed;
    fsba_pkg::scan_res_t want;
  } row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we = 1'b0;
  fsba_pkg::cfg_reg_e cfg_index = fsba_pkg::CFG_REGION_CAPACITY;
  logic [31:0]        cfg_wdata = '0;
  logic               req_valid = 1'b0;
  logic               req_ready;
  fsba_pkg::op_e      req_op = fsba_pkg::OP_ACQUIRE;
  logic [63:0]        req_cap = '0;
  logic [31:0]        req_idx = '0;
  logic               rsp_valid;
  logic               rsp_ready = 1'b0;
  logic [1:0]         rsp_status;
  logic [5:0]         rsp_granted;
  logic [6:0]         rsp_free;
  logic               rsp_idle;

  logic [31:0] region_cap = fsba_pkg::CAP_RESET;
  logic [6:0]  active_cfg = fsba_pkg::ACTIVE_RESET;
  logic [63:0] slots_out = '0;

  fsba_pkg::scan_res_t expected_results[$];
  row_t                directed_rows[$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct = 30;
  int unsigned recv_idle_pct = 62;
  int unsigned active_plan[PHASES] = '{64, 3, 1, 64, 100, 8, 0, 64, 2, 127};

  fixed_slot_bitmap_allocator #(
    .MAX_SLOTS(fsba_pkg::MAX_SLOTS_DEF)
  ) i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (req_valid),
    .in_ready_o        (req_ready),
    .operation_i       (req_op),
    .request_capacity_i(req_cap),
    .release_idx_i     (req_idx),
    .out_valid_o       (rsp_valid),
    .out_ready_i       (rsp_ready),
    .status_o          (rsp_status),
    .granted_slot_o    (rsp_granted),
    .free_count_o      (rsp_free),
    .idle_o            (rsp_idle)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [32:0] slot_bytes(logic [31:0] cap);
    logic [32:0] size;
    if ({1'b0, cap} <= fsba_pkg::MIN_SLOT_BYTES) begin
      return fsba_pkg::MIN_SLOT_BYTES;
    end
    if (cap > fsba_pkg::POW2_LIMIT) begin
      return ({1'b0, cap} + fsba_pkg::MIN_SLOT_BYTES - 33'd1) &
             ~(fsba_pkg::MIN_SLOT_BYTES - 33'd1);
    end
    size = fsba_pkg::MIN_SLOT_BYTES;
    while (size < {1'b0, cap}) begin
      size = size << 1;
    end
    return size;
  endfunction

  function automatic int unsigned live_slots();
    return (active_cfg > fsba_pkg::MAX_SLOTS_DEF) ? fsba_pkg::MAX_SLOTS_DEF
                                                  : int'(active_cfg);
  endfunction

  function automatic fsba_pkg::scan_res_t predict_request(fsba_pkg::op_e op,
                                                          logic [63:0] cap,
                                                          logic [31:0] idx);
    fsba_pkg::scan_res_t res;
    int unsigned         n;
    res = '{status: fsba_pkg::ST_OK, granted: '0, free_cnt: '0, idle: 1'b0};
    n = live_slots();
    if (op == fsba_pkg::OP_ACQUIRE) begin
      if (cap > {31'b0, slot_bytes(region_cap)}) begin
        res.status = fsba_pkg::ST_TOO_LARGE;
      end else begin
        res.status = fsba_pkg::ST_NO_FREE;
        for (int i = 0; i < n; i++) begin
          if (res.status == fsba_pkg::ST_NO_FREE && !slots_out[i]) begin
            slots_out[i] = 1'b1;
            res.granted = 6'(i);
            res.status = fsba_pkg::ST_OK;
          end
        end
      end
    end else if (idx >= n || !slots_out[idx[5:0]]) begin
      res.status = fsba_pkg::ST_BAD_RELEASE;
    end else begin
      slots_out[idx[5:0]] = 1'b0;
    end
    for (int i = 0; i < n; i++) begin
      if (!slots_out[i]) begin
        res.free_cnt = res.free_cnt + 7'd1;
      end
    end
    res.idle = (res.free_cnt == n);
    return res;
  endfunction

  task automatic report_mismatch(string what);
    if (mismatches < REPORT_LINES) begin
      $display("%0t ns: mismatch: %s", $time, what);
    end
    mismatches++;
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    end
  endtask

  task automatic add_write(fsba_pkg::cfg_reg_e which, logic [31:0] data);
    row_t row;
    row = '{kind: ROW_WRITE, which: which, wdata: data, op: fsba_pkg::OP_ACQUIRE,
            cap: '0, idx: '0, typed: 1'b0, want: '0};
    directed_rows.push_back(row);
  endtask

  task automatic add_request(fsba_pkg::op_e op, logic [63:0] cap, logic [31:0] idx);
    row_t row;
    row = '{kind: ROW_REQUEST, which: fsba_pkg::CFG_REGION_CAPACITY, wdata: '0, op: op,
            cap: cap, idx: idx, typed: 1'b0, want: '0};
    directed_rows.push_back(row);
  endtask

  task automatic add_known(fsba_pkg::op_e op, logic [63:0] cap, logic [31:0] idx,
                           fsba_pkg::status_e st, logic [5:0] granted,
                           logic [6:0] free_cnt);
    row_t row;
    row = '{kind: ROW_REQUEST, which: fsba_pkg::CFG_REGION_CAPACITY, wdata: '0, op: op,
            cap: cap, idx: idx, typed: 1'b1,
            want: '{status: st, granted: granted, free_cnt: free_cnt, idle: 1'b0}};
    directed_rows.push_back(row);
  endtask

  // Registers change only once every open request has been answered.
  task automatic write_config(fsba_pkg::cfg_reg_e which, logic [31:0] data);
    req_valid <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
    cfg_we <= 1'b1;
    cfg_index <= which;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (which == fsba_pkg::CFG_REGION_CAPACITY) begin
      region_cap = data;
    end else begin
      active_cfg = data[6:0];
    end
  endtask

  task automatic send_request(fsba_pkg::op_e op, logic [63:0] cap, logic [31:0] idx,
                              bit typed, fsba_pkg::scan_res_t want);
    fsba_pkg::scan_res_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk_i);
    end
    req_valid <= 1'b1;
    req_op <= op;
    req_cap <= cap;
    req_idx <= idx;
    do @(posedge clk_i); while (!req_ready);
    predicted = predict_request(op, cap, idx);
    expected_results.push_back(typed ? want : predicted);
  endtask

  task automatic random_request(int unsigned acquire_pct);
    logic [63:0]   size;
    logic [63:0]   cap;
    logic [31:0]   idx;
    int unsigned   held[$];
    int unsigned   pick;
    fsba_pkg::op_e op;
    size = {31'b0, slot_bytes(region_cap)};
    for (int i = 0; i < live_slots(); i++) begin
      if (slots_out[i]) begin
        held.push_back(i);
      end
    end
    op = ($urandom_range(99) < acquire_pct) ? fsba_pkg::OP_ACQUIRE : fsba_pkg::OP_RELEASE;
    case ($urandom_range(9))
      0: cap = size;
      1: cap = size + 64'd1 + 64'($urandom_range(255));
      2: cap = {$urandom, $urandom};
      default: cap = {$urandom, $urandom} % (size + 64'd1);
    endcase
    pick = $urandom_range(9);
    if (op == fsba_pkg::OP_RELEASE && held.size() != 0 && pick < 7) begin
      idx = held[$urandom_range(held.size() - 1)];
    end else if (pick < 9) begin
      idx = $urandom_range(fsba_pkg::MAX_SLOTS_DEF - 1);
    end else begin
      idx = $urandom;
    end
    send_request(op, cap, idx, 1'b0, '0);
  endtask

  always @(posedge clk_i) begin
    rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin : check_response
    fsba_pkg::scan_res_t want;
    if (rst_ni && rsp_valid && rsp_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("response with no request pending");
      end else begin
        want = expected_results.pop_front();
        check_field("status", rsp_status, want.status);
        check_field("granted_slot", rsp_granted, want.granted);
        check_field("free_count", rsp_free, want.free_cnt);
        check_field("idle", rsp_idle, want.idle);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned item;
    logic [31:0] cap_setting;
    add_known(fsba_pkg::OP_ACQUIRE, 64'd0, 32'd0, fsba_pkg::ST_OK, 6'd0, 7'd63);
    add_known(fsba_pkg::OP_ACQUIRE, 64'd256, 32'd0, fsba_pkg::ST_OK, 6'd1, 7'd62);
    add_known(fsba_pkg::OP_ACQUIRE, 64'd257, 32'd0, fsba_pkg::ST_TOO_LARGE, 6'd0, 7'd62);
    add_known(fsba_pkg::OP_ACQUIRE, '1, '1, fsba_pkg::ST_TOO_LARGE, 6'd0, 7'd62);
    add_known(fsba_pkg::OP_RELEASE, '1, 32'd0, fsba_pkg::ST_OK, 6'd0, 7'd63);
    add_known(fsba_pkg::OP_RELEASE, 64'd0, 32'd0, fsba_pkg::ST_BAD_RELEASE, 6'd0, 7'd63);
    add_known(fsba_pkg::OP_RELEASE, 64'd0, '1, fsba_pkg::ST_BAD_RELEASE, 6'd0, 7'd63);
    add_known(fsba_pkg::OP_RELEASE, 64'd0, 32'd64, fsba_pkg::ST_BAD_RELEASE, 6'd0, 7'd63);
    add_request(fsba_pkg::OP_ACQUIRE, 64'd1, 32'd0);
    // A capacity near the top carries into a 33-bit slot size.
    add_write(fsba_pkg::CFG_REGION_CAPACITY, 32'hFFFF_FFFF);
    add_request(fsba_pkg::OP_ACQUIRE, 64'h1_0000_0000, 32'd0);
    add_request(fsba_pkg::OP_ACQUIRE, 64'h1_0000_0001, 32'd0);
    add_write(fsba_pkg::CFG_REGION_CAPACITY, 32'h8000_0000);
    add_request(fsba_pkg::OP_ACQUIRE, 64'h8000_0000, 32'd0);
    add_request(fsba_pkg::OP_ACQUIRE, 64'h8000_0001, 32'd0);
    add_write(fsba_pkg::CFG_REGION_CAPACITY, 32'h8000_0001);
    add_request(fsba_pkg::OP_ACQUIRE, 64'h8000_0100, 32'd0);
    add_request(fsba_pkg::OP_ACQUIRE, 64'h8000_0101, 32'd0);
    add_write(fsba_pkg::CFG_REGION_CAPACITY, 32'd257);
    add_request(fsba_pkg::OP_ACQUIRE, 64'd512, 32'd0);
    add_request(fsba_pkg::OP_ACQUIRE, 64'd513, 32'd0);
    // Shrinking the pool leaves slots beyond it held but out of reach.
    add_write(fsba_pkg::CFG_ACTIVE_SLOTS, 32'd2);
    add_request(fsba_pkg::OP_ACQUIRE, 64'd0, 32'd0);
    add_request(fsba_pkg::OP_RELEASE, 64'd0, 32'd3);
    add_request(fsba_pkg::OP_RELEASE, 64'd0, 32'd1);
    add_write(fsba_pkg::CFG_ACTIVE_SLOTS, 32'hFFFF_FF80);
    add_request(fsba_pkg::OP_ACQUIRE, 64'd0, 32'd0);
    add_request(fsba_pkg::OP_RELEASE, 64'd0, 32'd0);
    add_request(fsba_pkg::OP_ACQUIRE, '1, 32'd0);
    add_write(fsba_pkg::CFG_ACTIVE_SLOTS, 32'd127);
    add_request(fsba_pkg::OP_ACQUIRE, 64'd0, 32'd0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_WRITE) begin
        write_config(directed_rows[r].which, directed_rows[r].wdata);
      end else begin
        send_request(directed_rows[r].op, directed_rows[r].cap, directed_rows[r].idx,
                     directed_rows[r].typed, directed_rows[r].want);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: cap_setting = 32'd0;
        1: cap_setting = 32'hFFFF_FF00;
        default: begin
          case ($urandom_range(3))
            0: cap_setting = $urandom_range(256);
            1: cap_setting = $urandom_range(32'h8000_0000, 257);
            2: cap_setting = $urandom_range(32'hFFFF_FFFF, 32'h8000_0001);
            default: cap_setting = $urandom;
          endcase
        end
      endcase
      write_config(fsba_pkg::CFG_REGION_CAPACITY, cap_setting);
      write_config(fsba_pkg::CFG_ACTIVE_SLOTS,
                   ($urandom & 32'hFFFF_FF80) | active_plan[phase]);
      for (int k = 0; k < PHASE_REQUESTS; k++) begin
        item = phase * PHASE_REQUESTS + k;
        if (item < 520) begin
          send_idle_pct = 30;
          recv_idle_pct = 62;
        end else if (item < 1040) begin
          send_idle_pct = 62;
          recv_idle_pct = 30;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        random_request((phase % 2 != 0) ? 75 : 50);
      end
    end

    req_valid <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
